>>> rtl/fcsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcsc_pkg;

    // Geometry limits and frame buffer layout.
    localparam int MAX_DIM         = 1024;
    localparam int BYTES_PER_PIXEL = 3;

    // Field widths.
    localparam int DIM_W    = 11;
    localparam int STRIDE_W = 13;
    localparam int COLOR_W  = 24;
    localparam int HALF_W   = $clog2(MAX_DIM);
    localparam int CX_W     = 12;
    localparam int CY_W     = 12;
    localparam int R_W      = 11;
    localparam int ROW_W    = 11;
    localparam int X_W      = 10;
    localparam int OFF_W    = 22;

    // Internal arithmetic widths.
    localparam int DY_W       = CY_W + 1;
    localparam int XC_W       = CX_W + 1;
    localparam int N_W        = 2 * R_W;
    localparam int RES_W      = N_W + 1;
    localparam int ROOT_W     = R_W;
    localparam int SQRT_STEPS = R_W;

    // Queue between the front and back ends.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DIM_W-1:0]    WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = DIM_W'(480);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1920);
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = COLOR_W'(24'h00CCCC);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STRIDE = 2'd2,
        REG_COLOR  = 2'd3
    } reg_idx_t;

    // Clamped half dimensions and line stride, shared by both ends.
    typedef struct packed {
        logic [HALF_W-1:0]   half_w;
        logic [HALF_W-1:0]   half_h;
        logic [STRIDE_W-1:0] stride;
    } geom_t;

    // One classified item on its way from the front end to the back end.
    // In the root pipeline rad_sq carries the running remainder.
    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic [N_W-1:0]         rad_sq;
        logic                   hit;
        logic [OFF_W-1:0]       row_offset;
    } work_t;

    // Clamp a dimension to 2..MAX_DIM and halve it.
    function automatic logic [HALF_W-1:0] half_dim(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] clamped;
        if (dim < DIM_W'(2))
        begin
            clamped = DIM_W'(2);
        end
        else if (dim > DIM_W'(MAX_DIM))
        begin
            clamped = DIM_W'(MAX_DIM);
        end
        else
        begin
            clamped = dim;
        end
        return clamped[HALF_W:1];
    endfunction

endpackage

`default_nettype wire

>>> rtl/fcsc_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [fcsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [fcsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output fcsc_pkg::geom_t                    geom
);

    logic [fcsc_pkg::DIM_W-1:0]    width_reg;
    logic [fcsc_pkg::DIM_W-1:0]    height_reg;
    logic [fcsc_pkg::STRIDE_W-1:0] stride_reg;
    logic [fcsc_pkg::COLOR_W-1:0]  color_reg;
    fcsc_pkg::reg_idx_t            reg_idx;
    logic                          wr_en;

    assign reg_idx = fcsc_pkg::reg_idx_t'(paddr[fcsc_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fcsc_pkg::WIDTH_RESET;
            height_reg <= fcsc_pkg::HEIGHT_RESET;
            stride_reg <= fcsc_pkg::STRIDE_RESET;
            color_reg  <= fcsc_pkg::COLOR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fcsc_pkg::REG_WIDTH:  width_reg  <= pwdata[fcsc_pkg::DIM_W-1:0];
                fcsc_pkg::REG_HEIGHT: height_reg <= pwdata[fcsc_pkg::DIM_W-1:0];
                fcsc_pkg::REG_STRIDE: stride_reg <= pwdata[fcsc_pkg::STRIDE_W-1:0];
                fcsc_pkg::REG_COLOR:  color_reg  <= pwdata[fcsc_pkg::COLOR_W-1:0];
                default:              width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            fcsc_pkg::REG_WIDTH:  prdata = fcsc_pkg::DATA_W'(width_reg);
            fcsc_pkg::REG_HEIGHT: prdata = fcsc_pkg::DATA_W'(height_reg);
            fcsc_pkg::REG_STRIDE: prdata = fcsc_pkg::DATA_W'(stride_reg);
            fcsc_pkg::REG_COLOR:  prdata = fcsc_pkg::DATA_W'(color_reg);
            default:              prdata = '0;
        endcase
    end

    assign geom.half_w = fcsc_pkg::half_dim(width_reg);
    assign geom.half_h = fcsc_pkg::half_dim(height_reg);
    assign geom.stride = stride_reg;

endmodule

`default_nettype wire

>>> rtl/fcsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsc_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [fcsc_pkg::CX_W-1:0]    center_x,
    input  wire logic signed [fcsc_pkg::CY_W-1:0]    center_y,
    input  wire logic        [fcsc_pkg::R_W-1:0]     radius,
    input  wire logic signed [fcsc_pkg::ROW_W-1:0]   row,
    input  wire fcsc_pkg::geom_t                     geom,
    input  wire logic                                q_full,
    output logic                                     busy,
    output logic                                     push,
    output fcsc_pkg::work_t                          push_data
);

    localparam int DW = fcsc_pkg::DY_W;
    localparam int YW = fcsc_pkg::ROW_W;
    localparam int HW = fcsc_pkg::HALF_W;
    localparam int PW = HW + fcsc_pkg::STRIDE_W;

    // Classification of the incoming item.
    logic signed [DW:0]   row_x;
    logic signed [DW:0]   cy_x;
    logic signed [DW:0]   dy_x;
    logic signed [DW:0]   rad_x;
    logic signed [DW:0]   dy_sum;
    logic [DW:0]          dy_mag;
    logic                 in_circle;
    logic signed [YW:0]   y_x;
    logic signed [YW:0]   hh_x;
    logic signed [YW:0]   top_sum;
    logic signed [YW:0]   row_diff;
    logic                 row_ok;
    logic                 stall;

    // First stage: classified item.
    logic                               s1_valid_reg;
    logic signed [fcsc_pkg::CX_W-1:0]   s1_cx_reg;
    logic [fcsc_pkg::R_W-1:0]           s1_rad_reg;
    logic [fcsc_pkg::R_W-1:0]           s1_dy_reg;
    logic                               s1_hit_reg;
    logic [HW-1:0]                      s1_row_dist_reg;

    // Second stage: products.
    logic                               s2_valid_reg;
    logic signed [fcsc_pkg::CX_W-1:0]   s2_cx_reg;
    logic [fcsc_pkg::N_W-1:0]           s2_rr_reg;
    logic [fcsc_pkg::N_W-1:0]           s2_dd_reg;
    logic                               s2_hit_reg;
    logic [fcsc_pkg::OFF_W-1:0]         s2_row_off_reg;

    logic [fcsc_pkg::N_W-1:0]                   rr_next;
    logic [fcsc_pkg::N_W-1:0]                   dd_next;
    logic [PW-1:0]                              row_prod;

    always_comb
    begin
        row_x     = {{(DW + 1 - YW){row[YW-1]}}, row};
        cy_x      = {{(DW + 1 - fcsc_pkg::CY_W){center_y[fcsc_pkg::CY_W-1]}}, center_y};
        rad_x     = {{(DW + 1 - fcsc_pkg::R_W){1'b0}}, radius};
        dy_x      = row_x - cy_x;
        dy_sum    = dy_x + rad_x;
        in_circle = (dy_x <= rad_x) && !dy_sum[DW];
        dy_mag    = dy_x[DW] ? -dy_x : dy_x;

        // Rows run from 1-H/2 up to H/2.
        y_x      = {row[YW-1], row};
        hh_x     = {{(YW + 1 - HW){1'b0}}, geom.half_h};
        top_sum  = y_x + hh_x;
        row_ok   = (y_x <= hh_x) && !top_sum[YW] && (top_sum != '0);
        row_diff = hh_x - y_x;
    end

    assign stall = s2_valid_reg && q_full;
    assign busy  = stall;

    assign rr_next  = fcsc_pkg::N_W'(s1_rad_reg) * fcsc_pkg::N_W'(s1_rad_reg);
    assign dd_next  = fcsc_pkg::N_W'(s1_dy_reg) * fcsc_pkg::N_W'(s1_dy_reg);
    assign row_prod = PW'(s1_row_dist_reg) * PW'(geom.stride);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_cx_reg       <= center_x;
            s1_rad_reg      <= radius;
            s1_dy_reg       <= dy_mag[fcsc_pkg::R_W-1:0];
            s1_hit_reg      <= in_circle && row_ok;
            s1_row_dist_reg <= row_diff[HW-1:0];

            s2_cx_reg       <= s1_cx_reg;
            s2_rr_reg       <= rr_next;
            s2_dd_reg       <= dd_next;
            s2_hit_reg      <= s1_hit_reg;
            s2_row_off_reg  <= row_prod[fcsc_pkg::OFF_W-1:0];
        end
    end

    assign push                 = s2_valid_reg && !q_full;
    assign push_data.cx         = s2_cx_reg;
    assign push_data.rad_sq     = s2_rr_reg - s2_dd_reg;
    assign push_data.hit        = s2_hit_reg;
    assign push_data.row_offset = s2_row_off_reg;

endmodule

`default_nettype wire

>>> rtl/fcsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fcsc_pkg::work_t  push_data,
    input  wire logic             pop,
    output fcsc_pkg::work_t       head,
    output logic                  full,
    output logic                  empty
);

    fcsc_pkg::work_t                entry_reg [fcsc_pkg::Q_DEPTH];
    logic [fcsc_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [fcsc_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [fcsc_pkg::Q_CNT_W-1:0]   count_reg;
    logic [fcsc_pkg::Q_CNT_W-1:0]   count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == fcsc_pkg::Q_CNT_W'(fcsc_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fcsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcsc_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire fcsc_pkg::work_t                      in_data,
    input  wire logic [fcsc_pkg::HALF_W-1:0]          half_w,
    output logic                                      done,
    output logic                                      span_valid,
    output logic signed [fcsc_pkg::X_W-1:0]           span_start,
    output logic signed [fcsc_pkg::X_W-1:0]           span_end,
    output logic        [fcsc_pkg::OFF_W-1:0]         start_offset
);

    localparam int STEPS = fcsc_pkg::SQRT_STEPS;
    localparam int RW    = fcsc_pkg::RES_W;
    localparam int NW    = fcsc_pkg::N_W;
    localparam int XW    = fcsc_pkg::X_W;
    localparam int CW    = fcsc_pkg::XC_W;

    // Root pipeline: one bit of the square root per stage.
    logic [STEPS-1:0]   st_valid_reg;
    fcsc_pkg::work_t    st_work_reg [STEPS];
    logic [RW-1:0]      st_root_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] STEP_BIT = RW'(1) << (NW - 2 - 2 * k);

        logic               valid_in;
        fcsc_pkg::work_t    work_in;
        logic [RW-1:0]      root_in;
        fcsc_pkg::work_t    work_out;
        logic [RW-1:0]      root_out;
        logic [RW-1:0]      trial;
        logic [RW-1:0]      rem_ext;
        logic [RW-1:0]      rem_diff;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign work_in  = in_data;
            assign root_in  = '0;
        end
        else
        begin : g_rest
            assign valid_in = st_valid_reg[k-1];
            assign work_in  = st_work_reg[k-1];
            assign root_in  = st_root_reg[k-1];
        end

        always_comb
        begin
            trial    = root_in + STEP_BIT;
            rem_ext  = {1'b0, work_in.rad_sq};
            rem_diff = rem_ext - trial;
            work_out = work_in;
            if (rem_ext >= trial)
            begin
                work_out.rad_sq = rem_diff[NW-1:0];
                root_out        = (root_in >> 1) + STEP_BIT;
            end
            else
            begin
                root_out = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k] <= 1'b0;
            end
            else
            begin
                st_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            st_work_reg[k] <= work_out;
            st_root_reg[k] <= root_out;
        end
    end

    // Clip stage.
    logic signed [CW-1:0]          cx_x;
    logic signed [CW-1:0]          half_x;
    logic signed [CW-1:0]          root_x;
    logic signed [CW-1:0]          left_x;
    logic signed [CW-1:0]          right_x;
    logic signed [CW-1:0]          lo_x;
    logic signed [CW-1:0]          hi_x;
    logic signed [CW-1:0]          left_clip;
    logic signed [CW-1:0]          right_clip;
    logic                          clip_ok;
    fcsc_pkg::work_t               last_work;
    logic [RW-1:0]                 last_root;

    logic                          clip_valid_reg;
    logic                          clip_ok_reg;
    logic signed [XW-1:0]          clip_x1_reg;
    logic signed [XW-1:0]          clip_x2_reg;
    logic [fcsc_pkg::OFF_W-1:0]    clip_row_off_reg;

    assign last_work = st_work_reg[STEPS-1];
    assign last_root = st_root_reg[STEPS-1];

    always_comb
    begin
        cx_x       = {last_work.cx[fcsc_pkg::CX_W-1], last_work.cx};
        root_x     = {{(CW - fcsc_pkg::ROOT_W){1'b0}}, last_root[fcsc_pkg::ROOT_W-1:0]};
        half_x     = {{(CW - fcsc_pkg::HALF_W){1'b0}}, half_w};
        left_x     = cx_x - root_x;
        right_x    = cx_x + root_x;
        lo_x       = -half_x;
        hi_x       = half_x - CW'(1);
        left_clip  = (left_x < lo_x) ? lo_x : left_x;
        right_clip = (right_x > hi_x) ? hi_x : right_x;
        clip_ok    = last_work.hit && (left_clip <= right_clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_valid_reg <= 1'b0;
        end
        else
        begin
            clip_valid_reg <= st_valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        clip_ok_reg      <= clip_ok;
        clip_x1_reg      <= left_clip[XW-1:0];
        clip_x2_reg      <= right_clip[XW-1:0];
        clip_row_off_reg <= last_work.row_offset;
    end

    // Output stage: column byte offset and result register.
    logic [XW:0]                   col;
    logic [fcsc_pkg::OFF_W-1:0]    col_bytes;
    logic [fcsc_pkg::OFF_W-1:0]    offset_sum;

    logic                          done_reg;
    logic                          span_valid_reg;
    logic signed [XW-1:0]          span_start_reg;
    logic signed [XW-1:0]          span_end_reg;
    logic [fcsc_pkg::OFF_W-1:0]    start_offset_reg;

    assign col        = {1'b0, half_w} + {clip_x1_reg[XW-1], clip_x1_reg};
    assign col_bytes  = {{(fcsc_pkg::OFF_W - XW - 1){1'b0}}, col}
                        * fcsc_pkg::OFF_W'(fcsc_pkg::BYTES_PER_PIXEL);
    assign offset_sum = clip_row_off_reg + col_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= clip_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        span_valid_reg   <= clip_ok_reg;
        span_start_reg   <= clip_ok_reg ? clip_x1_reg : '0;
        span_end_reg     <= clip_ok_reg ? clip_x2_reg : '0;
        start_offset_reg <= clip_ok_reg ? offset_sum : '0;
    end

    assign done         = done_reg;
    assign span_valid   = span_valid_reg;
    assign span_start   = span_start_reg;
    assign span_end     = span_end_reg;
    assign start_offset = start_offset_reg;

endmodule

`default_nettype wire

>>> rtl/filled_circle_span_clipper.sv
`timescale 1ns / 1ps
`default_nettype none

// Filled circle span clipper.
// The caller issues one item per scanline: a circle (center_x, center_y, radius)
// and the row to evaluate, by raising start while busy is low. The block returns
// the clipped horizontal span of the filled circle on that row together with the
// frame buffer byte offset of its first pixel. Each result appears on the result
// ports for exactly one cycle, flagged by done; span_valid is low, and the other
// fields are zero, for rows that miss the circle or the image.
// Throughput is one item per cycle: the front end classifies the row and forms
// r*r - dy*dy, a four-entry queue hands items over, and the back end runs an
// eleven-stage root pipeline (one root bit per stage) followed by clip and offset
// stages. The receiver cannot stall, so the back end drains the queue every cycle
// and busy stays low in normal use.
// Image width, height, line stride and fill color sit behind an APB-style port
// and should only be changed while no items are in flight. Reset loads the
// default 640 x 480 geometry and empties every pipeline stage and the queue.
module filled_circle_span_clipper (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [fcsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic        [fcsc_pkg::DATA_W-1:0]   pwdata,
    output logic             [fcsc_pkg::DATA_W-1:0]   prdata,
    output logic                                      pready,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [fcsc_pkg::CX_W-1:0]     center_x,
    input  wire logic signed [fcsc_pkg::CY_W-1:0]     center_y,
    input  wire logic        [fcsc_pkg::R_W-1:0]      radius,
    input  wire logic signed [fcsc_pkg::ROW_W-1:0]    row,
    output logic                                      done,
    output logic                                      span_valid,
    output logic signed      [fcsc_pkg::X_W-1:0]      span_start,
    output logic signed      [fcsc_pkg::X_W-1:0]      span_end,
    output logic             [fcsc_pkg::OFF_W-1:0]    start_offset
);

    // Clamped geometry, driven straight from the configuration registers.
    fcsc_pkg::geom_t    geom;

    // Handover between front and back ends.
    logic               q_push;
    fcsc_pkg::work_t    q_push_data;
    fcsc_pkg::work_t    q_head;
    logic               q_full;
    logic               q_empty;

    fcsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    // The front end checks the row against the circle and the image rows, then
    // forms the squared half-width and the row part of the byte offset.
    fcsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .row       (row),
        .geom      (geom),
        .q_full    (q_full),
        .busy      (busy),
        .push      (q_push),
        .push_data (q_push_data)
    );

    fcsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (!q_empty),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end takes the head item every cycle the queue holds one.
    fcsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (!q_empty),
        .in_data      (q_head),
        .half_w       (geom.half_w),
        .done         (done),
        .span_valid   (span_valid),
        .span_start   (span_start),
        .span_end     (span_end),
        .start_offset (start_offset)
    );

    // Every accepted item comes out as a done pulse.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##16 done)
        else $error("result missing at the expected latency");

    // The back end drains the queue every cycle, so it can never fill up.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("front end stalled on a full queue");

    // An empty span carries zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !span_valid) |-> (span_start == '0) && (span_end == '0)
                                  && (start_offset == '0))
        else $error("invalid span with nonzero fields");

    // A valid span is never reversed.
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && span_valid) |-> (span_start <= span_end))
        else $error("span start beyond span end");

endmodule

`default_nettype wire

>>> bench/filled_circle_span_clipper_tb.sv
`timescale 1ns / 1ps

module filled_circle_span_clipper_tb;

    // One result as seen on the result ports.
    typedef struct packed {
        logic                              valid;
        logic signed [fcsc_pkg::X_W-1:0]   x_lo;
        logic signed [fcsc_pkg::X_W-1:0]   x_hi;
        logic [fcsc_pkg::OFF_W-1:0]        offset;
    } span_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [fcsc_pkg::ADDR_W-1:0]          paddr = '0;
    logic [fcsc_pkg::DATA_W-1:0]          pwdata = '0;
    logic [fcsc_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic signed [fcsc_pkg::CX_W-1:0]     center_x = '0;
    logic signed [fcsc_pkg::CY_W-1:0]     center_y = '0;
    logic [fcsc_pkg::R_W-1:0]             radius = '0;
    logic signed [fcsc_pkg::ROW_W-1:0]    row = '0;
    logic                                 done;
    logic                                 span_valid;
    logic signed [fcsc_pkg::X_W-1:0]      span_start;
    logic signed [fcsc_pkg::X_W-1:0]      span_end;
    logic [fcsc_pkg::OFF_W-1:0]           start_offset;

    // Mirror of the geometry registers, loaded with the reset values.
    logic [fcsc_pkg::DIM_W-1:0]           cfg_width = fcsc_pkg::WIDTH_RESET;
    logic [fcsc_pkg::DIM_W-1:0]           cfg_height = fcsc_pkg::HEIGHT_RESET;
    logic [fcsc_pkg::STRIDE_W-1:0]        cfg_stride = fcsc_pkg::STRIDE_RESET;

    // Spans predicted for accepted items, oldest first.
    span_t                      pending_spans[$];
    int unsigned                mismatch_count = 0;

    // When set, the sender never inserts idle cycles between items.
    bit                         steady = 1'b0;

    filled_circle_span_clipper i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .row          (row),
        .done         (done),
        .span_valid   (span_valid),
        .span_start   (span_start),
        .span_end     (span_end),
        .start_offset (start_offset)
    );

    always #1 clk = ~clk;

    // Hard limit on the run time.
    initial
    begin
        #500000;
        $display("filled_circle_span_clipper_tb: FAIL");
        $finish;
    end

    // A dimension register is clamped to 2..MAX_DIM before it is halved.
    function automatic int half_extent(input logic [fcsc_pkg::DIM_W-1:0] dim);
        int v;
        v = dim;
        if (v < 2)
        begin
            v = 2;
        end
        else if (v > fcsc_pkg::MAX_DIM)
        begin
            v = fcsc_pkg::MAX_DIM;
        end
        return v / 2;
    endfunction

    // Exact floor of the square root, found by bisection over the radius range.
    function automatic int floor_root(input int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 1 << fcsc_pkg::R_W;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Expected span of one row under the current register mirror.
    function automatic span_t predict_span(
        input logic signed [fcsc_pkg::CX_W-1:0]  cx_in,
        input logic signed [fcsc_pkg::CY_W-1:0]  cy_in,
        input logic [fcsc_pkg::R_W-1:0]          rad_in,
        input logic signed [fcsc_pkg::ROW_W-1:0] row_in
    );
        span_t  s;
        int     cx;
        int     cy;
        int     r;
        int     y;
        int     hw;
        int     hh;
        int     dy;
        int     b;
        int     x1;
        int     x2;
        longint line_bytes;
        longint off;
        s = '0;
        cx = cx_in;
        cy = cy_in;
        r = rad_in;
        y = row_in;
        hw = half_extent(cfg_width);
        hh = half_extent(cfg_height);
        dy = y - cy;
        // Rows that miss the circle or the image give an empty span.
        if (dy < -r || dy > r || y < 1 - hh || y > hh)
        begin
            return s;
        end
        b = floor_root(r * r - dy * dy);
        x1 = (cx - b < -hw) ? -hw : cx - b;
        x2 = (cx + b > hw - 1) ? hw - 1 : cx + b;
        if (x1 > x2)
        begin
            return s;
        end
        line_bytes = cfg_stride;
        off = longint'(hh - y) * line_bytes
              + longint'(hw + x1) * fcsc_pkg::BYTES_PER_PIXEL;
        s.valid = 1'b1;
        s.x_lo = fcsc_pkg::X_W'(x1);
        s.x_hi = fcsc_pkg::X_W'(x2);
        s.offset = fcsc_pkg::OFF_W'(off);
        return s;
    endfunction

    // Every done pulse is matched against the oldest predicted span.
    always @(posedge clk)
    begin : check_results
        span_t want;
        if (rst_n && done)
        begin
            if (pending_spans.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: result with no item outstanding:", $realtime);
                    $display("    valid=%0b start=%0d end=%0d off=%0d",
                             span_valid, span_start, span_end, start_offset);
                end
            end
            else
            begin
                want = pending_spans.pop_front();
                if (span_valid !== want.valid || span_start !== want.x_lo ||
                    span_end !== want.x_hi || start_offset !== want.offset)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: span mismatch:", $realtime);
                        $display("    expected valid=%0b start=%0d end=%0d off=%0d",
                                 want.valid, want.x_lo, want.x_hi, want.offset);
                        $display("    actual   valid=%0b start=%0d end=%0d off=%0d",
                                 span_valid, span_start, span_end, start_offset);
                    end
                end
            end
        end
    end

    // Random idle cycles before an item, about one cycle in four.
    task automatic idle_gaps();
        if (!steady)
        begin
            while ($urandom_range(99) < 26)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Issue one row and queue its predicted span once the block takes it.
    // The port values are read after the accepting edge, so the prediction
    // sees exactly what the block accepted.
    task automatic issue_row(input int cx, input int cy, input int r, input int y);
        idle_gaps();
        center_x <= fcsc_pkg::CX_W'(cx);
        center_y <= fcsc_pkg::CY_W'(cy);
        radius   <= fcsc_pkg::R_W'(r);
        row      <= fcsc_pkg::ROW_W'(y);
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_spans.push_back(predict_span(center_x, center_y, radius, row));
    endtask

    // Stop issuing and wait until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_spans.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One register write: setup cycle, then access cycle. The trailing
    // edge keeps back-to-back writes from touching psel twice in one step.
    task automatic write_reg(input fcsc_pkg::reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fcsc_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= fcsc_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fcsc_pkg::REG_WIDTH:  cfg_width  = fcsc_pkg::DIM_W'(value);
            fcsc_pkg::REG_HEIGHT: cfg_height = fcsc_pkg::DIM_W'(value);
            fcsc_pkg::REG_STRIDE: cfg_stride = fcsc_pkg::STRIDE_W'(value);
            default:              ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned stride, input int unsigned color);
        write_reg(fcsc_pkg::REG_WIDTH, w);
        write_reg(fcsc_pkg::REG_HEIGHT, h);
        write_reg(fcsc_pkg::REG_STRIDE, stride);
        write_reg(fcsc_pkg::REG_COLOR, color);
    endtask

    // Rows against the 640 x 480 geometry left by reset.
    task automatic test_reset_geometry();
        issue_row(0, 0, 0, 0);              // zero radius on its own row
        issue_row(5, 10, 0, 11);            // zero radius, next row is empty
        issue_row(0, 0, 100, 100);          // row tangent to the circle
        issue_row(0, 0, 100, 101);          // row just past the circle
        issue_row(0, 240, 50, 240);         // top row of the image
        issue_row(0, 240, 50, 241);         // one row above the image
        issue_row(0, -239, 50, -239);       // bottom row of the image
        issue_row(0, -240, 50, -240);       // one row below the image
        issue_row(0, 0, 2047, 0);           // clipped on both sides
        issue_row(2047, 0, 100, 0);         // entirely right of the image
        issue_row(-2048, 0, 100, 0);        // entirely left of the image
        issue_row(329, 0, 10, 0);           // single pixel at the right edge
        issue_row(330, 0, 10, 0);           // just past the right edge
        issue_row(-2048, -2048, 2047, -512);
        issue_row(2047, 2047, 2047, 512);
        issue_row(17, -300, 600, -1024);    // most negative row code
        issue_row(-17, 300, 900, 1023);     // most positive row code
        wait_for_results();
    endtask

    // Dimension clamps at both ends and a width that is odd.
    task automatic test_dimension_clamp();
        set_geometry(1, 0, 6, 0);           // both clamp up to 2
        issue_row(0, 0, 5, 0);
        issue_row(0, 1, 5, 1);
        issue_row(0, 0, 5, 2);
        issue_row(0, 0, 5, -1);
        wait_for_results();
        set_geometry(2047, 2047, 3072, 24'hFFFFFF);   // both clamp down to MAX_DIM
        issue_row(0, 0, 2047, 512);
        issue_row(0, 0, 2047, -511);
        issue_row(0, -512, 0, -512);
        wait_for_results();
        // With a width of 7 the columns run from -3 to 2.
        set_geometry(7, 480, 21, 24'h123456);
        issue_row(0, 0, 10, 0);
        issue_row(2, 0, 0, 0);
        issue_row(3, 0, 0, 0);
        wait_for_results();
    endtask

    // A large stride makes the byte offset wrap at 22 bits.
    task automatic test_offset_wrap();
        set_geometry(1024, 1024, 8191, 24'hA5A5A5);
        issue_row(0, -511, 1000, -511);
        issue_row(511, -400, 3, -400);
        issue_row(-300, 100, 200, -50);
        wait_for_results();
    endtask

    // Random rows over several geometries. Most items are rows that cross
    // or graze a circle placed near the image; the rest are arbitrary codes.
    task automatic test_random_rows();
        int hw;
        int hh;
        int cx;
        int cy;
        int r;
        int y;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_geometry(640, 480, 1920, $urandom_range(0, 24'hFFFFFF));
                1: set_geometry(2, 2, 6, 0);
                2: set_geometry(1024, 1024, 8191, 24'hFFFFFF);
                4: set_geometry(33, 1000, 0, $urandom_range(0, 24'hFFFFFF));
                default: set_geometry($urandom_range(0, 2047), $urandom_range(0, 2047),
                                      $urandom_range(0, 8191), $urandom_range(0, 24'hFFFFFF));
            endcase
            // One whole phase runs back to back with no idle cycles.
            steady = (phase == 2);
            hw = half_extent(cfg_width);
            hh = half_extent(cfg_height);
            for (int k = 0; k < 150; k++)
            begin
                // Halfway through one phase the sender waits for an empty pipe.
                if (phase == 4 && k == 75)
                begin
                    wait_for_results();
                end
                if ($urandom_range(99) < 75)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        r = $urandom_range(0, 2047);
                    end
                    else
                    begin
                        r = $urandom_range(0, hw + 8);
                    end
                    cx = int'($urandom_range(0, 2 * hw + 40)) - hw - 20;
                    cy = int'($urandom_range(0, 2 * hh + 40)) - hh - 19;
                    if ($urandom_range(3) != 0)
                    begin
                        y = cy + int'($urandom_range(0, 2 * r)) - r;
                    end
                    else
                    begin
                        y = int'($urandom_range(0, 2 * hh + 4)) - hh - 1;
                    end
                    if (y > 1023)
                    begin
                        y = 1023;
                    end
                    else if (y < -1024)
                    begin
                        y = -1024;
                    end
                end
                else
                begin
                    cx = $urandom_range(0, 4095);
                    cy = $urandom_range(0, 4095);
                    r  = $urandom_range(0, 2047);
                    y  = $urandom_range(0, 2047);
                end
                issue_row(cx, cy, r, y);
            end
            wait_for_results();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_dimension_clamp();
        test_offset_wrap();
        test_random_rows();
        wait_for_results();
        // Let any stray result show up before the verdict.
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("filled_circle_span_clipper_tb: PASS");
        end
        else
        begin
            $display("filled_circle_span_clipper_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fcsc_pkg.sv
rtl/fcsc_regs.sv
rtl/fcsc_front.sv
rtl/fcsc_queue.sv
rtl/fcsc_back.sv
rtl/filled_circle_span_clipper.sv
bench/filled_circle_span_clipper_tb.sv
